@@ hw/rtl/sacd_pkg.sv @@
package sacd_pkg;

    localparam int DEF_SET_BITS  = 7;
    localparam int DEF_LINE_BITS = 5;
    localparam int DEF_WAYS      = 8;
    localparam int DEF_ADDR_BITS = 32;

    typedef struct packed {
        logic        mode;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [6:0]  set_index;
        logic [2:0]  way;
        logic        writeback;
        logic [31:0] writeback_address;
        logic [31:0] fill_address;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    localparam logic MODE_WRITE = 1'b1;

    function automatic int tag_width(int addr_bits, int set_bits, int line_bits);
        int w;
        w = addr_bits - set_bits - line_bits;
        return (w > 0) ? w : 1;
    endfunction

    function automatic int way_width(int ways);
        return (ways > 1) ? $clog2(ways) : 1;
    endfunction

    function automatic int set_width(int set_bits);
        return (set_bits > 0) ? set_bits : 1;
    endfunction

    function automatic int row_width(int addr_bits, int set_bits, int line_bits, int ways);
        return ways * (tag_width(addr_bits, set_bits, line_bits) + 2 + way_width(ways));
    endfunction

endpackage

@@ hw/rtl/sacd_ram.sv @@
module sacd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/sacd_lookup.sv @@
module sacd_lookup #(
    parameter int SET_BITS  = sacd_pkg::DEF_SET_BITS,
    parameter int LINE_BITS = sacd_pkg::DEF_LINE_BITS,
    parameter int WAYS      = sacd_pkg::DEF_WAYS,
    parameter int ADDR_BITS = sacd_pkg::DEF_ADDR_BITS,
    localparam int ROW_W = sacd_pkg::row_width(ADDR_BITS, SET_BITS, LINE_BITS, WAYS)
) (
    input  sacd_pkg::req_t   req,
    input  logic [ROW_W-1:0] row_rd,
    output logic [ROW_W-1:0] row_wr,
    output logic [ROW_W-1:0] row_init,
    output sacd_pkg::rsp_t   res
);
    import sacd_pkg::*;

    localparam int TAG_W   = tag_width(ADDR_BITS, SET_BITS, LINE_BITS);
    localparam int WAY_W   = way_width(WAYS);
    localparam int SET_W   = set_width(SET_BITS);
    localparam int TAG_SH  = SET_BITS + LINE_BITS;
    localparam int VAL_OFF = WAYS * TAG_W;
    localparam int DIR_OFF = VAL_OFF + WAYS;
    localparam int ORD_OFF = DIR_OFF + WAYS;
    localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << SET_BITS) - 1);

    logic [ADDR_BITS-1:0] addr;
    logic [SET_W-1:0]     set_idx;
    logic [TAG_W-1:0]     tag;
    logic [TAG_W-1:0]     tags [WAYS];
    logic [TAG_W-1:0]     tags_n [WAYS];
    logic [WAYS-1:0]      valid;
    logic [WAYS-1:0]      valid_n;
    logic [WAYS-1:0]      dirty;
    logic [WAYS-1:0]      dirty_n;
    logic [WAY_W-1:0]     order [WAYS];
    logic [WAY_W-1:0]     order_n [WAYS];
    logic                 hit;
    logic [WAY_W-1:0]     way;
    logic [WAY_W-1:0]     pos;
    logic                 wb;
    logic [ADDR_BITS-1:0] wb_addr;
    logic [ADDR_BITS-1:0] fill_addr;

    always_comb
    begin
        addr    = req.address[ADDR_BITS-1:0];
        set_idx = SET_W'(addr >> LINE_BITS) & SET_MASK;
        tag     = TAG_W'(addr >> TAG_SH);

        for (int w = 0; w < WAYS; w++)
        begin
            tags[w]  = row_rd[w*TAG_W +: TAG_W];
            valid[w] = row_rd[VAL_OFF + w];
            dirty[w] = row_rd[DIR_OFF + w];
            order[w] = row_rd[ORD_OFF + w*WAY_W +: WAY_W];
        end

        // parallel tag compare, lowest matching way wins
        hit = 1'b0;
        way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && valid[w] && tags[w] == tag)
            begin
                hit = 1'b1;
                way = WAY_W'(w);
            end
        end
        if (!hit)
        begin
            way = order[0];
        end

        wb        = !hit && valid[way] && dirty[way];
        wb_addr   = wb ? ((ADDR_BITS'(tags[way]) << TAG_SH) |
                          (ADDR_BITS'(set_idx) << LINE_BITS)) : '0;
        fill_addr = hit ? '0 : ((addr >> LINE_BITS) << LINE_BITS);

        for (int w = 0; w < WAYS; w++)
        begin
            tags_n[w] = tags[w];
        end
        valid_n = valid;
        dirty_n = dirty;
        if (!hit)
        begin
            tags_n[way]  = tag;
            valid_n[way] = 1'b1;
            dirty_n[way] = 1'b0;
        end
        if (req.mode == MODE_WRITE)
        begin
            dirty_n[way] = 1'b1;
        end

        // move the used way to the most recent end
        pos = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (order[i] == way)
            begin
                pos = WAY_W'(i);
            end
        end
        for (int i = 0; i < WAYS - 1; i++)
        begin
            order_n[i] = (i < int'(pos)) ? order[i] : order[i+1];
        end
        order_n[WAYS-1] = way;

        for (int w = 0; w < WAYS; w++)
        begin
            row_wr[w*TAG_W +: TAG_W]            = tags_n[w];
            row_wr[VAL_OFF + w]                 = valid_n[w];
            row_wr[DIR_OFF + w]                 = dirty_n[w];
            row_wr[ORD_OFF + w*WAY_W +: WAY_W]  = order_n[w];
            row_init[w*TAG_W +: TAG_W]           = '0;
            row_init[VAL_OFF + w]                = 1'b0;
            row_init[DIR_OFF + w]                = 1'b0;
            row_init[ORD_OFF + w*WAY_W +: WAY_W] = WAY_W'(w);
        end

        res.hit               = hit;
        res.set_index         = 7'(set_idx);
        res.way               = 3'(way);
        res.writeback         = wb;
        res.writeback_address = 32'(wb_addr);
        res.fill_address      = 32'(fill_addr);
    end

endmodule

@@ hw/rtl/set_assoc_lru_cache_directory_top.sv @@
// channel  signals                       payload
// req      req_valid / req_ready / req   mode, address
// rsp      rsp_valid / rsp_ready / rsp   hit, set_index, way, writeback, writeback_address,
//                                        fill_address
//
// an access: the transfer cycle issues the set read, the lookup state then compares all ways,
// picks the hit way or, on a miss, the lru victim and writes the set row back to the same ram
// after reset the set ram is cleared one row a cycle, all 2**SET_BITS rows, req_ready low
// a waiting result holds the lookup cycle; the output register frees the next transfer
module set_assoc_lru_cache_directory_top #(
    parameter int SET_BITS  = sacd_pkg::DEF_SET_BITS,
    parameter int LINE_BITS = sacd_pkg::DEF_LINE_BITS,
    parameter int WAYS      = sacd_pkg::DEF_WAYS,
    parameter int ADDR_BITS = sacd_pkg::DEF_ADDR_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  sacd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output sacd_pkg::rsp_t rsp
);
    import sacd_pkg::*;

    localparam int ROW_W    = row_width(ADDR_BITS, SET_BITS, LINE_BITS, WAYS);
    localparam int SET_W    = set_width(SET_BITS);
    localparam int NUM_SETS = 1 << SET_BITS;
    localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << SET_BITS) - 1);
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] clr_cnt_next;
    req_t             req_reg;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             rsp_load;

    logic             ram_wr_en;
    logic [SET_W-1:0] ram_wr_addr;
    logic [ROW_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [SET_W-1:0] ram_rd_addr;
    logic [ROW_W-1:0] ram_rd_data;
    logic [ROW_W-1:0] row_wr;
    logic [ROW_W-1:0] row_init;
    rsp_t             res;
    logic [SET_W-1:0] held_set;

    sacd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sacd_lookup #(
        .SET_BITS  (SET_BITS),
        .LINE_BITS (LINE_BITS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_lookup (
        .req      (req_reg),
        .row_rd   (ram_rd_data),
        .row_wr   (row_wr),
        .row_init (row_init),
        .res      (res)
    );

    assign ram_rd_en   = req_valid && req_ready;
    assign ram_rd_addr = SET_W'(req.address[ADDR_BITS-1:0] >> LINE_BITS) & SET_MASK;
    assign held_set    = SET_W'(req_reg.address[ADDR_BITS-1:0] >> LINE_BITS) & SET_MASK;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_ready    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = held_set;
        ram_wr_data  = row_wr;
        rsp_load     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = row_init;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ram_wr_en  = 1'b1;
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (rsp_load)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_lookup_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == ST_LOOKUP)
        else $error("transfer not followed by lookup");

    a_rsp_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result without lookup");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> state_reg != ST_IDLE)
        else $error("ram write while idle");

    a_wb_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.writeback |-> rsp_reg.writeback_address == '0)
        else $error("write-back address without write-back");

    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.hit |-> !rsp_reg.writeback && rsp_reg.fill_address == '0)
        else $error("hit with fill or write-back");

endmodule

@@ tb/sv/tb_set_assoc_lru_cache_directory_top.sv @@
module tb_set_assoc_lru_cache_directory_top;

    import sacd_pkg::*;

    localparam int   NUM_SETS   = 1 << DEF_SET_BITS;
    localparam int   NUM_WAYS   = DEF_WAYS;
    localparam int   TAG_LSB    = DEF_SET_BITS + DEF_LINE_BITS;
    localparam logic MODE_READ  = ~MODE_WRITE;
    localparam int   DRAIN_WAIT = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int errors = 0;
    int access_count = 0;
    int result_count = 0;
    int hit_count = 0;
    int writeback_count = 0;

    logic [19:0] line_tag [NUM_SETS*NUM_WAYS];
    logic        line_valid [NUM_SETS*NUM_WAYS];
    logic        line_dirty [NUM_SETS*NUM_WAYS];
    logic [2:0]  lru_order [NUM_SETS][NUM_WAYS];

    rsp_t pending_rsps [$];
    rsp_t want;

    set_assoc_lru_cache_directory_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic rsp_t lookup_line(input logic m, input logic [31:0] a);
        rsp_t        r;
        logic [6:0]  s;
        logic [19:0] t;
        int          base;
        int          pos;
        logic        found;
        logic [2:0]  v;
        s = a[TAG_LSB-1:DEF_LINE_BITS];
        t = a[31:TAG_LSB];
        base = int'(s) * NUM_WAYS;
        found = 1'b0;
        v = '0;
        pos = 0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && line_valid[base+w] && line_tag[base+w] == t)
            begin
                found = 1'b1;
                v = 3'(w);
            end
        end
        r = '0;
        r.hit = found;
        r.set_index = s;
        if (!found)
        begin
            v = lru_order[s][0];
            if (line_valid[base+v] && line_dirty[base+v])
            begin
                r.writeback = 1'b1;
                r.writeback_address = {line_tag[base+v], s, {DEF_LINE_BITS{1'b0}}};
            end
            r.fill_address = {a[31:DEF_LINE_BITS], {DEF_LINE_BITS{1'b0}}};
            line_tag[base+v] = t;
            line_valid[base+v] = 1'b1;
            line_dirty[base+v] = 1'b0;
        end
        if (m == MODE_WRITE)
            line_dirty[base+v] = 1'b1;
        // move the used way to the most recent end
        for (int i = 0; i < NUM_WAYS; i++)
            if (lru_order[s][i] == v)
                pos = i;
        for (int i = pos; i + 1 < NUM_WAYS; i++)
            lru_order[s][i] = lru_order[s][i+1];
        lru_order[s][NUM_WAYS-1] = v;
        r.way = v;
        return r;
    endfunction

    task automatic send_access(input logic m, input logic [31:0] a);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req.mode = m;
        req.address = a;
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsps.insert(pending_rsps.size(), lookup_line(m, a));
        access_count++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, rsp);
            end
            else
            begin
                want = pending_rsps.pop_front();
                result_count++;
                if (want.hit)
                    hit_count++;
                if (want.writeback)
                    writeback_count++;
                check_field("hit", 32'(want.hit), 32'(rsp.hit));
                check_field("set_index", 32'(want.set_index), 32'(rsp.set_index));
                check_field("way", 32'(want.way), 32'(rsp.way));
                check_field("writeback", 32'(want.writeback), 32'(rsp.writeback));
                check_field("writeback_address", want.writeback_address,
                            rsp.writeback_address);
                check_field("fill_address", want.fill_address, rsp.fill_address);
            end
        end
    end

    task automatic test_directed_corners();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // first fill, same line at both offset extremes, write hit
        send_access(MODE_READ, 32'h0000_0000);
        send_access(MODE_READ, 32'h0000_001F);
        send_access(MODE_WRITE, 32'h0000_0010);
        // write miss at the top of the address space, then read hit
        send_access(MODE_WRITE, 32'hFFFF_FFFF);
        send_access(MODE_READ, 32'hFFFF_FFE0);
        // fill the rest of set 0
        for (int t = 1; t < NUM_WAYS; t++)
            send_access(MODE_READ, t << TAG_LSB);
        // dirty victim written back, then a clean victim
        send_access(MODE_READ, 8 << TAG_LSB);
        send_access(MODE_READ, 9 << TAG_LSB);
        // write hits and a read hit on a dirty line
        send_access(MODE_WRITE, (2 << TAG_LSB) | 32'h4);
        send_access(MODE_WRITE, 3 << TAG_LSB);
        send_access(MODE_READ, 3 << TAG_LSB);
        // evict round the set until the dirty ways go
        for (int t = 10; t < 18; t++)
            send_access(MODE_READ, t << TAG_LSB);
    endtask

    task automatic run_random(input int n, input int src_pct, input int sink_pct);
        logic [19:0] tag_pool [12];
        logic [6:0]  set_pool [5];
        logic [31:0] a;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 12; i++)
            tag_pool[i] = 20'($urandom());
        set_pool[0] = '0;
        set_pool[1] = '1;
        for (int i = 2; i < 5; i++)
            set_pool[i] = 7'($urandom());
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 85)
                a = {tag_pool[$urandom_range(0, 11)], set_pool[$urandom_range(0, 4)],
                     5'($urandom())};
            else
                a = $urandom();
            send_access(1'($urandom_range(0, 1)), a);
        end
    endtask

    task automatic test_random_streaming();
        run_random(420, 0, 0);
    endtask

    task automatic test_random_sender_gaps();
        run_random(420, 59, 0);
    endtask

    task automatic test_random_receiver_stalls();
        run_random(420, 0, 59);
    endtask

    task automatic test_random_both_idle();
        run_random(420, 20, 20);
    endtask

    initial
    begin
        foreach (line_valid[i])
        begin
            line_tag[i] = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
        end
        foreach (lru_order[s, w])
            lru_order[s][w] = 3'(w);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_corners();
        test_random_streaming();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        req_valid = 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d accesses sent, %0d results checked", access_count, result_count);
        $display("%0d hits, %0d dirty write-backs", hit_count, writeback_count);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sacd_pkg.sv
hw/rtl/sacd_ram.sv
hw/rtl/sacd_lookup.sv
hw/rtl/set_assoc_lru_cache_directory_top.sv
tb/sv/tb_set_assoc_lru_cache_directory_top.sv
